>>> sv/mrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the Miller-Rabin prime tester
// Holds the base table, the early-exit bounds and the modmul handshake structs.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned NumBases = 12;
  localparam int unsigned BaseIdxW = 4;

  typedef logic [62:0] word_t;

  // modular multiplier request/response controls
  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  localparam word_t BOUND_1 = 63'd1373653;
  localparam word_t BOUND_2 = 63'd25326001;
  localparam word_t PSEUDO  = 63'd3215031751;
  localparam word_t BOUND_3 = 63'd25000000000;
  localparam word_t BOUND_4 = 63'd2152302898747;
  localparam word_t BOUND_5 = 63'd341550071728321;

  function automatic logic [5:0] base_of(input logic [BaseIdxW-1:0] idx);
    logic [5:0] b;
    case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

endpackage

>>> sv/mrpt_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_modmul: bit-serial modular multiplier
// Computes (a * b) mod n, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mrpt_modmul
  import mrpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mm_ctrl_t ctrl,
  input  word_t    a,
  input  word_t    b,
  input  word_t    n,
  output mm_stat_t stat,
  output word_t    r
);

  logic        busy;
  logic [5:0]  cnt;
  word_t       bsh;
  logic [63:0] dbl;
  logic [63:0] dbl_red;
  logic [63:0] add;
  logic [63:0] add_red;
  logic        done;

  // double, reduce, conditionally add and reduce
  always_comb begin
    dbl     = {r, 1'b0};
    dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    add     = dbl_red + {1'b0, a};
    add_red = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
  end

  // step through the multiplier bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'd62;
        bsh  <= b;
        r    <= '0;
      end else if (busy) begin
        r   <= bsh[62] ? add_red[62:0] : dbl_red[62:0];
        bsh <= {bsh[61:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (!rst && stat.done) begin
      assert (!busy) else $error("modmul done while busy");
    end
  end

  assert property (@(posedge clk) disable iff (rst) stat.done |-> $past(busy))
    else $error("done without a running product");
  assert property (@(posedge clk) disable iff (rst) (ctrl.start && !busy) |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= 6'd62)
    else $error("bit counter out of range");

endmodule

>>> sv/miller_rabin_prime_test_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64: deterministic 64-bit primality tester
// Sequencer of Miller-Rabin rounds over a shared bit-serial modmul.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel number/valid/ready takes one signed candidate; the output
//   channel is_prime/out_valid/out_ready returns one bit per candidate.
//   Values below 2 answer 0, 2 and 3 answer 1, all others run strong
//   probable-prime rounds with bases 2..37, stopping at the known bounds.
//   Sequence: each modular product passes through start, the multiplier
//   bits and the result. One exponent bit takes a dispatch, a multiply
//   when the bit is set, and a square; a round covers the exponent bits
//   plus its squarings, and a worst case prime runs all twelve rounds.
//   Values below 4 go straight from the transfer to the output state;
//   every other value, even ones included, runs at least the full
//   base-2 round.
//   Throughput: one candidate at a time; in_ready is high only while idle.
//   The result sits in an output register until taken; while out_ready is
//   low the block holds it and accepts no new candidate.
//   Reset: synchronous rst returns to idle with no result pending.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64
  import mrpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_prime
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROUND = 4'd1;
  localparam logic [3:0] S_PMUL  = 4'd2;
  localparam logic [3:0] S_PSQ   = 4'd3;
  localparam logic [3:0] S_PNEXT = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQW   = 4'd7;
  localparam logic [3:0] S_NEXT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FACT  = 4'd10;
  localparam logic [3:0] S_SHR   = 4'd11;

  logic [3:0]          state;
  word_t               n;
  word_t               d;
  logic [5:0]          s;
  word_t               e;
  word_t               acc;
  word_t               bb;
  logic [5:0]          i;
  logic [BaseIdxW-1:0] k;
  logic                wait_mm;

  mm_ctrl_t mm_ctrl;
  mm_stat_t mm_stat;
  word_t    mm_a, mm_b, mm_r;
  word_t    nm1;

  assign nm1 = n - 63'd1;

  mrpt_modmul u_mm (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mm_ctrl),
    .a    (mm_a),
    .b    (mm_b),
    .n    (n),
    .stat (mm_stat),
    .r    (mm_r)
  );

  // choose multiplier operands from state
  always_comb begin
    mm_ctrl.start = 1'b0;
    mm_a = acc;
    mm_b = bb;
    case (state)
      S_PMUL: begin
        mm_a = acc;
        mm_b = bb;
        mm_ctrl.start = !wait_mm;
      end
      S_PSQ: begin
        mm_a = bb;
        mm_b = bb;
        mm_ctrl.start = !wait_mm;
      end
      S_SQW: begin
        mm_a = acc;
        mm_b = acc;
        mm_ctrl.start = !wait_mm;
      end
      default: ;
    endcase
  end

  // early-exit after round k passed
  function automatic logic early_exit(input logic [BaseIdxW-1:0] kk, input word_t nn);
    logic r;
    case (kk)
      4'd1:    r = nn < BOUND_1;
      4'd2:    r = nn < BOUND_2;
      4'd3:    r = nn < BOUND_3;
      4'd4:    r = nn < BOUND_4;
      4'd6:    r = nn < BOUND_5;
      4'd11:   r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign in_ready = (state == S_IDLE) && !out_valid;

  // sequence the rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wait_mm   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mm_ctrl.start) wait_mm <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            n <= number[62:0];
            if (number[63] || number[62:0] < 63'd2) begin
              is_prime <= 1'b0;
              state    <= S_OUT;
            end else if (number[62:0] < 63'd4) begin
              is_prime <= 1'b1;
              state    <= S_OUT;
            end else begin
              d     <= number[62:0] - 63'd1;
              s     <= '0;
              k     <= '0;
              state <= S_FACT;
            end
          end
        end
        S_FACT: begin
          // strip one trailing zero a cycle
          if (!d[0] && s < 6'd63) begin
            d <= {1'b0, d[62:1]};
            s <= s + 6'd1;
          end else begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          acc   <= 63'd1;
          bb    <= {57'd0, base_of(k)};
          e     <= d;
          state <= S_SHR;
        end
        S_SHR: begin
          // bases are below n except when n is small; reduce by repeated subtraction
          if (bb >= n) bb <= bb - n;
          else state <= S_PNEXT;
        end
        S_PNEXT: begin
          if (e == '0) state <= S_CHECK;
          else if (e[0]) state <= S_PMUL;
          else state <= S_PSQ;
        end
        S_PMUL: begin
          if (mm_stat.done) begin
            acc     <= mm_r;
            wait_mm <= 1'b0;
            state   <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (mm_stat.done) begin
            bb      <= mm_r;
            e       <= {1'b0, e[62:1]};
            wait_mm <= 1'b0;
            state   <= S_PNEXT;
          end
        end
        S_CHECK: begin
          i <= 6'd1;
          if (acc == 63'd1 || acc == nm1) state <= S_NEXT;
          else state <= S_SQ;
        end
        S_SQ: begin
          if (i < s) state <= S_SQW;
          else begin
            is_prime <= 1'b0;
            state    <= S_OUT;
          end
        end
        S_SQW: begin
          if (mm_stat.done) begin
            acc     <= mm_r;
            wait_mm <= 1'b0;
            i       <= i + 6'd1;
            if (mm_r == nm1) state <= S_NEXT;
            else state <= S_SQ;
          end
        end
        S_NEXT: begin
          if (k == 4'd3 && n == PSEUDO) begin
            is_prime <= 1'b0;
            state    <= S_OUT;
          end else if (early_exit(k, n)) begin
            is_prime <= 1'b1;
            state    <= S_OUT;
          end else begin
            k     <= k + 4'd1;
            state <= S_ROUND;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state != S_OUT)
    else $error("result overwritten while pending");
  assert property (@(posedge clk) disable iff (rst) (state == S_OUT) |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !mm_stat.busy)
    else $error("ready while multiplier busy");

endmodule
